// ===== rtl/process_slot_table_round_robin_macros.svh =====
// ----------------------------------------------------------------------------
// Slot table assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SLOT_TABLE_ROUND_ROBIN_MACROS_SVH
`define PROCESS_SLOT_TABLE_ROUND_ROBIN_MACROS_SVH

// condition holds at every edge out of reset
`define PST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define PST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot table package
// Request and result types, request and status codes, slot states.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_FW   = 4;

  typedef enum logic [1:0] {
    REQ_CREATE    = 2'd0,
    REQ_REMOVE    = 2'd1,
    REQ_SCHED     = 2'd2,
    REQ_HAS_CHILD = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NOT_USED = 2'd2
  } sts_t;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_ZOMBIE  = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SLOT_FW-1:0] slot_id;
  } pst_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_FW-1:0] slot_out;
    logic [SLOT_FW-1:0] prev_slot;
    logic               flag;
  } pst_out_t;

endpackage

`default_nettype wire

// ===== rtl/pst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/process_slot_table_round_robin.sv =====
// ----------------------------------------------------------------------------
// Task slot table with round-robin scheduling
// Channels: in (valid/stall) carries one request {req_type, slot_id};
// out (valid/stall) returns exactly one result {status, slot_out, prev_slot,
// flag} per request, in request order. No configuration port.
// Slot state and parent sit in one RAM word per slot, read one slot a cycle
// from the registered RAM port; per-slot valid flops mark entries written.
// A request walks the table one slot per cycle starting at its scan start,
// pipelined behind the RAM read. Create stops at the first slot not running,
// schedule at the first running slot, has-child at the first child, remove
// reads one slot. A full-table create or a bad remove id skips the scan.
// One request is in flight at a time; in_stall stays high until its result
// has been loaded into the output register.
// Reset: all slots empty, current slot, allocation pointer and running count
// zero, output empty. The RAM needs no clearing pass.
// A stalled out holds its result; the finished next result waits until the
// output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "process_slot_table_round_robin_macros.svh"

module process_slot_table_round_robin #(
  parameter int SLOTS = pst_pkg::SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pst_pkg::pst_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pst_pkg::pst_out_t     out_data
);

  import pst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = IW + 2;
  localparam int XW = IW + SLOT_FW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t          state_r;
  req_t            op_r;
  logic [SLOT_FW-1:0] id_r;
  logic [IW-1:0]   iss_idx_r;
  logic [IW-1:0]   iss_cnt_r;
  logic            iss_done_r;
  logic            pend_r;
  logic [IW-1:0]   pend_idx_r;
  logic            pend_last_r;
  logic [IW-1:0]   cur_r;
  logic [IW-1:0]   alloc_r;
  logic [CW-1:0]   cnt_r;
  logic [SLOTS-1:0] vld_r;
  pst_out_t        res_r;
  pst_out_t        out_r;
  logic            out_valid_r;

  logic            rd_en;
  logic [EW-1:0]   rd_data;
  slot_st_t        ent_st;
  logic [IW-1:0]   ent_par;
  logic            chk;
  logic            hit;
  logic            finish;
  logic            last_issue;
  logic [IW-1:0]   lim;
  logic            mem_we;
  logic [EW-1:0]   mem_wdata;
  logic            out_free;
  logic            in_xfer;
  logic            load_out;
  logic            sched_hit;
  logic [IW-1:0]   start_idx;
  logic            start_skip;
  pst_out_t        start_res;
  pst_out_t        scan_res;

  function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i);
    nxt_idx = (i == IW'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  pst_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(pend_idx_r),
    .wdata(mem_wdata),
    .re   (rd_en),
    .raddr(iss_idx_r),
    .rdata(rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == S_DONE) && out_free;

  assign rd_en   = (state_r == S_SCAN) && !iss_done_r;
  assign ent_st  = vld_r[pend_idx_r] ? slot_st_t'(rd_data[EW-1:IW]) : ST_EMPTY;
  assign ent_par = rd_data[IW-1:0];
  assign chk     = (state_r == S_SCAN) && pend_r;

  always_comb begin
    case (op_r)
      REQ_CREATE:    hit = (ent_st != ST_RUNNING);
      REQ_REMOVE:    hit = 1'b1;
      REQ_SCHED:     hit = (ent_st == ST_RUNNING);
      REQ_HAS_CHILD: hit = (ent_st != ST_EMPTY) && (XW'(ent_par) == XW'(id_r));
      default:       hit = 1'b0;
    endcase
  end

  assign finish     = chk && (hit || pend_last_r);
  assign sched_hit  = chk && (op_r == REQ_SCHED) && hit;
  assign lim        = (op_r == REQ_HAS_CHILD) ? IW'(SLOTS - 2) : IW'(SLOTS - 1);
  assign last_issue = (op_r == REQ_REMOVE) || (iss_cnt_r == lim);

  assign mem_we = chk && (((op_r == REQ_CREATE) && hit) ||
                          ((op_r == REQ_REMOVE) && (ent_st == ST_RUNNING)));
  assign mem_wdata = (op_r == REQ_CREATE) ? {ST_RUNNING, cur_r} : {ST_ZOMBIE, ent_par};

  // scan start and early result of a new request
  always_comb begin
    start_idx  = '0;
    start_skip = 1'b0;
    start_res  = '0;
    case (req_t'(in_data.req_type))
      REQ_CREATE: begin
        start_idx = alloc_r;
        if (cnt_r >= CW'(SLOTS)) begin
          start_skip       = 1'b1;
          start_res.status = STS_FULL;
        end
      end
      REQ_REMOVE: begin
        start_idx = IW'(in_data.slot_id);
        if (XW'(in_data.slot_id) >= XW'(SLOTS)) begin
          start_skip       = 1'b1;
          start_res.status = STS_NOT_USED;
        end
      end
      REQ_SCHED:     start_idx = nxt_idx(cur_r);
      REQ_HAS_CHILD: start_idx = IW'(1);
      default:       start_idx = '0;
    endcase
  end

  // result at the end of a scan
  always_comb begin
    scan_res = '0;
    case (op_r)
      REQ_CREATE: begin
        if (hit) begin
          scan_res.slot_out = SLOT_FW'(pend_idx_r);
        end else begin
          scan_res.status = STS_FULL;
        end
      end
      REQ_REMOVE: begin
        if (ent_st == ST_EMPTY) begin
          scan_res.status = STS_NOT_USED;
        end
      end
      REQ_SCHED: begin
        scan_res.prev_slot = SLOT_FW'(cur_r);
        scan_res.slot_out  = hit ? SLOT_FW'(pend_idx_r) : SLOT_FW'(cur_r);
        scan_res.flag      = hit && (pend_idx_r != cur_r);
      end
      REQ_HAS_CHILD: scan_res.flag = hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      cur_r       <= '0;
      alloc_r     <= '0;
      cnt_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_r       <= res_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r       <= req_t'(in_data.req_type);
            id_r       <= in_data.slot_id;
            iss_idx_r  <= start_idx;
            iss_cnt_r  <= '0;
            iss_done_r <= 1'b0;
            pend_r     <= 1'b0;
            res_r      <= start_res;
            state_r    <= start_skip ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          pend_r <= rd_en && !finish;
          if (rd_en) begin
            pend_idx_r  <= iss_idx_r;
            pend_last_r <= last_issue;
            iss_idx_r   <= nxt_idx(iss_idx_r);
            iss_cnt_r   <= iss_cnt_r + 1'b1;
            if (last_issue) begin
              iss_done_r <= 1'b1;
            end
          end
          if (finish) begin
            res_r   <= scan_res;
            state_r <= S_DONE;
            case (op_r)
              REQ_CREATE: begin
                if (hit) begin
                  vld_r[pend_idx_r] <= 1'b1;
                  cnt_r             <= cnt_r + 1'b1;
                  alloc_r           <= nxt_idx(pend_idx_r);
                end
              end
              REQ_REMOVE: begin
                if ((ent_st == ST_RUNNING) && (cnt_r != '0)) begin
                  cnt_r <= cnt_r - 1'b1;
                end
              end
              REQ_SCHED: begin
                if (hit) begin
                  cur_r <= pend_idx_r;
                end
              end
              default: ;
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PST_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall, "block not busy after transfer")
  `PST_ASSERT_ALWAYS(a_count_range, cnt_r <= CW'(SLOTS), "running count above slot count")
  `PST_ASSERT_ALWAYS(a_cur_range, cur_r <= IW'(SLOTS - 1), "current slot out of range")
  `PST_ASSERT_ALWAYS(a_alloc_range, alloc_r <= IW'(SLOTS - 1), "alloc pointer out of range")
  `PST_ASSERT_SAME(a_sched_needs_running, sched_hit, cnt_r != '0, "running slot, zero count")
  `PST_ASSERT_NEXT(a_done_loads_out, load_out, out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule

`default_nettype wire
